FILE: rtl/particle_pool_engine_assert.svh
// Assertion macros shared by the RTL.
`ifndef PARTICLE_POOL_ENGINE_ASSERT_SVH
`define PARTICLE_POOL_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk_i, disabled in reset.
`define PPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppe check failed");

// Next-cycle implication.
`define PPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppe sequence check failed");

`endif

FILE: rtl/ppe_pkg.sv
`default_nettype none
package ppe_pkg;

  localparam int unsigned POOL_SIZE_DEF = 64;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned IN_DATA_W     = 160;
  localparam int unsigned OUT_DATA_W    = 120;
  localparam int unsigned CFG_W         = 20;

  localparam logic [19:0] GRAVITY_RST = 20'd51200;
  localparam logic [15:0] DAMPING_RST = 16'd64225;

  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_DAMPING = 1'b1;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] ST_SPAWNED = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REPORT  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TRD, S_TLD, S_MUL, S_PUSH, S_FIN
  } state_e;

  // last field lowest
  typedef struct packed {
    logic [2:0]         pad;
    logic [15:0]        tick_dt;
    logic               spawn_gravity;
    logic [9:0]         spawn_life;
    logic [31:0]        spawn_color;
    logic [7:0]         spawn_radius;
    logic signed [20:0] spawn_vel_y;
    logic signed [20:0] spawn_vel_x;
    logic signed [23:0] spawn_pos_y;
    logic signed [23:0] spawn_pos_x;
  } in_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [9:0]         life_start;
    logic [9:0]         life_left;
    logic [31:0]        out_color;
    logic [7:0]         out_radius;
    logic signed [23:0] out_pos_y;
    logic signed [23:0] out_pos_x;
    logic [SLOT_W-1:0]  slot;
  } out_t;

  typedef struct packed {
    logic               gravity;
    logic [7:0]         radius;
    logic [31:0]        color;
    logic [9:0]         life_start;
    logic [9:0]         life_left;
    logic signed [20:0] vel_y;
    logic signed [20:0] vel_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
  } entry_t;

  typedef struct packed {
    out_t       data;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic ram_we;
    logic ram_re;
    logic out_load;
    logic pend_load;
    logic idx_inc;
  } ctl_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [22:0] v);
    if (v > 23'sd1048575) begin
      return 21'sh0FFFFF;
    end else if (v < -23'sd1048576) begin
      return 21'sh100000;
    end
    return v[20:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ppe_ram.sv
`default_nettype none
module ppe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/particle_pool_engine.sv
// Particle pool engine.
// Input stream (s_axis_*): one beat per command. tuser = kind (0 spawn, 1 tick);
// tdata carries the spawn fields and the tick time step. A beat is taken only
// while the engine is idle, so tready is low while a command is in work.
// Config port: cfg_we_i/cfg_idx_i/cfg_wdata_i writes gravity (0) or damping (1);
// write only while idle.
// Output stream (m_axis_*): tuser = status, tlast = final beat of a command.
// Spawn: the free-slot scan visits one slot per cycle and ends at the first free
// slot (pool full after a full scan). Tick: inactive slots are skipped; each
// active slot goes through RAM read, five products through the single shared
// multiplier, write-back and hand-off.
// Survivors are reported in slot order; one report is held back so the last
// one can carry tlast. A tick with no survivors sends nothing.
// The output register decouples the receiver; when it stalls the walk pauses
// at the hand-off step and no beat is lost.
// Reset clears all slot valid flags and restores the register defaults
// (gravity 200.0, damping 0.98); the particle RAM needs no clearing.
`default_nettype none
module particle_pool_engine #(
  parameter int unsigned POOL_SIZE = ppe_pkg::POOL_SIZE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, radius, color, life, gravity, dt, zero pad
  input  wire logic [ppe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // slot, pos_x, pos_y, radius, color, life_left, life_start, zero pad
  output logic [ppe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [ppe_pkg::CFG_W-1:0]      cfg_wdata_i
);
  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned EW = $bits(ppe_pkg::entry_t);

  ppe_pkg::state_e state_q, state_d;
  ppe_pkg::ctl_t   ctl;
  ppe_pkg::in_t    in_q;
  ppe_pkg::entry_t ent_q, rd_ent, wr_ent;
  ppe_pkg::res_t   pend_q, new_q, out_q, pend_src;

  logic [19:0]          grav_q;
  logic [15:0]          damp_q;
  logic                 kind_q;
  logic [POOL_SIZE-1:0] active_q;
  logic [IW-1:0]        idx_q;
  logic                 idx_last;
  logic                 cur_active;
  logic [2:0]           step_q;
  logic                 pend_v_q, out_v_q, surv_q, out_free;
  logic [EW-1:0]        rd_raw;

  // shared multiplier
  logic signed [21:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [38:0] prod_q, prod_rnd;
  logic signed [22:0] rnd;
  logic signed [23:0] px_q, py_q;
  logic signed [20:0] vx_q, vy_q;

  assign idx_last   = (idx_q == IW'(POOL_SIZE - 1));
  assign cur_active = active_q[idx_q];
  assign out_free   = !out_v_q || m_axis_tready;
  assign rd_ent     = ppe_pkg::entry_t'(rd_raw);
  assign prod_rnd   = prod_q + 39'sd32768;
  assign rnd        = prod_rnd[38:16];

  always_comb begin
    mul_a = {vx_q[20], vx_q};
    mul_b = $signed({1'b0, in_q.tick_dt});
    case (step_q)
      3'd0: begin mul_a = {vx_q[20], vx_q}; mul_b = $signed({1'b0, in_q.tick_dt}); end
      3'd1: begin mul_a = {vy_q[20], vy_q}; mul_b = $signed({1'b0, in_q.tick_dt}); end
      3'd2: begin mul_a = $signed({2'b00, grav_q}); mul_b = $signed({1'b0, in_q.tick_dt}); end
      3'd3: begin mul_a = {vx_q[20], vx_q}; mul_b = $signed({1'b0, damp_q}); end
      3'd4: begin mul_a = {vy_q[20], vy_q}; mul_b = $signed({1'b0, damp_q}); end
      default: begin mul_a = {vy_q[20], vy_q}; mul_b = $signed({1'b0, damp_q}); end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppe_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == ppe_pkg::KIND_TICK) ? ppe_pkg::S_TRD : ppe_pkg::S_SCAN;
        end
      end
      ppe_pkg::S_SCAN: begin
        if (!cur_active || idx_last) state_d = ppe_pkg::S_FIN;
      end
      ppe_pkg::S_TRD: begin
        if (cur_active)    state_d = ppe_pkg::S_TLD;
        else if (idx_last) state_d = ppe_pkg::S_FIN;
      end
      ppe_pkg::S_TLD: state_d = ppe_pkg::S_MUL;
      ppe_pkg::S_MUL: begin
        if (step_q == 3'd5) state_d = ppe_pkg::S_PUSH;
      end
      ppe_pkg::S_PUSH: begin
        if (!surv_q || !pend_v_q || out_free) begin
          state_d = idx_last ? ppe_pkg::S_FIN : ppe_pkg::S_TRD;
        end
      end
      ppe_pkg::S_FIN: begin
        if (!pend_v_q || out_free) state_d = ppe_pkg::S_IDLE;
      end
      default: state_d = ppe_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ppe_pkg::S_IDLE: s_axis_tready = 1'b1;
      ppe_pkg::S_SCAN: begin
        ctl.ram_we    = !cur_active;
        ctl.pend_load = !cur_active || idx_last;
        ctl.idx_inc   = cur_active && !idx_last;
      end
      ppe_pkg::S_TRD: begin
        ctl.ram_re  = cur_active;
        ctl.idx_inc = !cur_active && !idx_last;
      end
      ppe_pkg::S_MUL: ctl.ram_we = (step_q == 3'd5);
      ppe_pkg::S_PUSH: begin
        ctl.out_load  = surv_q && pend_v_q && out_free;
        ctl.pend_load = surv_q && (!pend_v_q || out_free);
        ctl.idx_inc   = (!surv_q || !pend_v_q || out_free) && !idx_last;
      end
      ppe_pkg::S_FIN: ctl.out_load = pend_v_q && out_free;
      default: ctl = '0;
    endcase
  end

  // RAM write data: fresh spawn or updated particle
  always_comb begin
    if (state_q == ppe_pkg::S_SCAN) begin
      wr_ent.pos_x      = in_q.spawn_pos_x;
      wr_ent.pos_y      = in_q.spawn_pos_y;
      wr_ent.vel_x      = in_q.spawn_vel_x;
      wr_ent.vel_y      = in_q.spawn_vel_y;
      wr_ent.life_left  = in_q.spawn_life;
      wr_ent.life_start = in_q.spawn_life;
      wr_ent.color      = in_q.spawn_color;
      wr_ent.radius     = in_q.spawn_radius;
      wr_ent.gravity    = in_q.spawn_gravity;
    end else begin
      wr_ent           = ent_q;
      wr_ent.pos_x     = px_q;
      wr_ent.pos_y     = py_q;
      wr_ent.vel_x     = vx_q;
      wr_ent.vel_y     = rnd[20:0];
      wr_ent.life_left = (ent_q.life_left <= 10'd1) ? 10'd0 : ent_q.life_left - 10'd1;
    end
  end

  // record going into the hold-back register
  always_comb begin
    pend_src = new_q;
    if (state_q == ppe_pkg::S_SCAN) begin
      pend_src.last = 1'b1;
      if (!cur_active) begin
        pend_src.status          = ppe_pkg::ST_SPAWNED;
        pend_src.data.pad        = '0;
        pend_src.data.slot       = ppe_pkg::SLOT_W'(idx_q);
        pend_src.data.out_pos_x  = in_q.spawn_pos_x;
        pend_src.data.out_pos_y  = in_q.spawn_pos_y;
        pend_src.data.out_radius = in_q.spawn_radius;
        pend_src.data.out_color  = in_q.spawn_color;
        pend_src.data.life_left  = in_q.spawn_life;
        pend_src.data.life_start = in_q.spawn_life;
      end else begin
        pend_src.status = ppe_pkg::ST_FULL;
        pend_src.data   = '0;
      end
    end
  end

  ppe_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl.ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_ent),
    .re_i    (ctl.ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ppe_pkg::S_IDLE;
      grav_q   <= ppe_pkg::GRAVITY_RST;
      damp_q   <= ppe_pkg::DAMPING_RST;
      active_q <= '0;
      idx_q    <= '0;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ppe_pkg::CFG_GRAVITY: grav_q <= cfg_wdata_i;
          ppe_pkg::CFG_DAMPING: damp_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idx_q <= '0;
      end else if (ctl.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (state_q == ppe_pkg::S_SCAN && !cur_active) begin
        active_q[idx_q] <= 1'b1;
      end else if (state_q == ppe_pkg::S_MUL && step_q == 3'd5 && ent_q.life_left <= 10'd1) begin
        active_q[idx_q] <= 1'b0;
      end
      if (state_q == ppe_pkg::S_MUL) begin
        step_q <= (step_q == 3'd5) ? 3'd0 : step_q + 3'd1;
      end
      if (ctl.pend_load) begin
        pend_v_q <= 1'b1;
      end else if (ctl.out_load) begin
        pend_v_q <= 1'b0;
      end
      if (ctl.out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q   <= ppe_pkg::in_t'(s_axis_tdata);
      kind_q <= s_axis_tuser;
    end
    prod_q <= mul_a * mul_b;
    if (state_q == ppe_pkg::S_TLD) begin
      ent_q <= rd_ent;
      px_q  <= rd_ent.pos_x;
      py_q  <= rd_ent.pos_y;
      vx_q  <= rd_ent.vel_x;
      vy_q  <= rd_ent.vel_y;
    end
    if (state_q == ppe_pkg::S_MUL) begin
      case (step_q)
        3'd1: px_q <= ppe_pkg::sat24({px_q[23], px_q} + {{2{rnd[22]}}, rnd});
        3'd2: py_q <= ppe_pkg::sat24({py_q[23], py_q} + {{2{rnd[22]}}, rnd});
        3'd3: begin
          if (ent_q.gravity) vy_q <= ppe_pkg::sat21({{2{vy_q[20]}}, vy_q} + rnd);
        end
        3'd4: vx_q <= rnd[20:0];
        3'd5: begin
          surv_q                 <= (ent_q.life_left > 10'd1);
          new_q.status           <= ppe_pkg::ST_REPORT;
          new_q.last             <= 1'b0;
          new_q.data.pad         <= '0;
          new_q.data.slot        <= ppe_pkg::SLOT_W'(idx_q);
          new_q.data.out_pos_x   <= px_q;
          new_q.data.out_pos_y   <= py_q;
          new_q.data.out_radius  <= ent_q.radius;
          new_q.data.out_color   <= ent_q.color;
          new_q.data.life_left   <= ent_q.life_left - 10'd1;
          new_q.data.life_start  <= ent_q.life_start;
        end
        default: ;
      endcase
    end
    if (ctl.pend_load) begin
      pend_q <= pend_src;
    end
    if (ctl.out_load) begin
      out_q.data   <= pend_q.data;
      out_q.status <= pend_q.status;
      out_q.last   <= (state_q == ppe_pkg::S_FIN);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

  `include "particle_pool_engine_assert.svh"

  `PPE_ASSERT_NOW(a_idle_empty, s_axis_tready, !pend_v_q)
  `PPE_ASSERT_NOW(a_load_free, ctl.out_load, out_free && pend_v_q)
  `PPE_ASSERT_NXT(a_mul_done, state_q == ppe_pkg::S_MUL && step_q == 3'd5, state_q == ppe_pkg::S_PUSH)
  `PPE_ASSERT_NOW(a_tick_kind, state_q == ppe_pkg::S_MUL, kind_q == ppe_pkg::KIND_TICK)
endmodule
`default_nettype wire
